// ===== rtl/core/ewpd_pkg.sv =====
package ewpd_pkg;

  localparam int CHAR_W   = 8;
  localparam int HELD_N   = 3;   // pending characters of a base64 group
  localparam int BUNDLE_N = 3;   // most bytes one character decodes to

  // decode_mode codes
  localparam logic [1:0] MODE_B = 2'd0;
  localparam logic [1:0] MODE_Q = 2'd1;

  // register select, taken from paddr[2]
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_WIDEN = 1'b1;

  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_US    = 8'h5F;  // '_'
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] UTF8_LEAD = 8'hC0;
  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] LOW6_MASK = 8'h3F;

  // One request's decoded bytes, before Latin-1 widening
  typedef struct packed {
    logic [BUNDLE_N-1:0][7:0] bytes;
    logic [1:0]               cnt;
    logic                     last;
  } ewpd_bundle_t;

  // Base64 alphabet lookup: {valid, sextet}
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B)               r = {1'b1, 6'd62};
    else if (c == 8'h2F)               r = {1'b1, 6'd63};
    return r;
  endfunction

  // Hex digit lookup, either case: {valid, nibble}
  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    return r;
  endfunction

endpackage

// ===== rtl/core/ewpd_in_if.sv =====
interface ewpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_char;
  logic       last_char;

  modport source (output valid, payload_char, last_char, input ready);
  modport sink   (input valid, payload_char, last_char, output ready);
endinterface

// ===== rtl/core/ewpd_out_if.sv =====
interface ewpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       no_data;
  logic       end_of_word;

  modport source (output valid, out_byte, no_data, end_of_word, input ready);
  modport sink   (input valid, out_byte, no_data, end_of_word, output ready);
endinterface

// ===== rtl/core/ewpd_front.sv =====
module ewpd_front import ewpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   decode_mode,
  input  logic         cfg_clear,
  input  logic         in_valid,
  input  logic [7:0]   in_char,
  input  logic         in_last,
  output logic         in_ready,
  input  logic         q_full,
  output logic         q_push,
  output ewpd_bundle_t q_data
);

  logic [HELD_N-1:0][7:0] held_r, held_nxt;
  logic [1:0]             hc_r, hc_nxt;
  logic                   halt_r, halt_nxt;

  logic [BUNDLE_N-1:0][7:0] bytes;
  logic [1:0]               nb;
  logic [6:0]               sa, sb, sx, sy;
  logic [4:0]               hc_val, h1_val;
  logic                     fresh;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Decode one character into up to three bytes and the next pending state
  always_comb begin
    held_nxt = held_r;
    hc_nxt   = hc_r;
    halt_nxt = halt_r;
    bytes    = '0;
    nb       = 2'd0;
    fresh    = 1'b0;
    sa       = sextet(held_r[0]);
    sb       = sextet(held_r[1]);
    sx       = sextet(held_r[2]);
    sy       = sextet(in_char);
    hc_val   = hexval(in_char);
    h1_val   = hexval(held_r[1]);

    if (decode_mode == MODE_B) begin
      if (!halt_r) begin
        if (hc_r != 2'd3) begin
          held_nxt[hc_r] = in_char;
          hc_nxt         = hc_r + 2'd1;
        end else begin
          hc_nxt = 2'd0;
          if (!sa[6] || !sb[6]) begin
            halt_nxt = 1'b1;
          end else begin
            bytes[nb] = {sa[5:0], sb[5:4]};
            nb        = nb + 2'd1;
            if (sx[6]) begin
              bytes[nb] = {sb[3:0], sx[5:2]};
              nb        = nb + 2'd1;
            end
            // padded third with valid fourth keeps the high bits set
            if (sy[6]) begin
              bytes[nb] = {(sx[6] ? sx[1:0] : 2'b11), sy[5:0]};
              nb        = nb + 2'd1;
            end
          end
        end
      end
    end else if (decode_mode == MODE_Q) begin
      if (hc_r == 2'd1) begin
        if (hc_val[4]) begin
          held_nxt[1] = in_char;
          hc_nxt      = 2'd2;
        end else begin
          bytes[nb] = CH_EQ;
          nb        = nb + 2'd1;
          hc_nxt    = 2'd0;
          fresh     = 1'b1;
        end
      end else if (hc_r >= 2'd2) begin
        hc_nxt = 2'd0;
        if (hc_val[4]) begin
          bytes[nb] = {h1_val[3:0], hc_val[3:0]};
          nb        = nb + 2'd1;
        end else begin
          bytes[nb] = CH_EQ;
          nb        = nb + 2'd1;
          bytes[nb] = held_r[1];
          nb        = nb + 2'd1;
          fresh     = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end

      // character outside an escape
      if (fresh) begin
        if (in_char == CH_US) begin
          bytes[nb] = CH_SPACE;
          nb        = nb + 2'd1;
        end else if (in_char == CH_EQ) begin
          held_nxt[0] = CH_EQ;
          hc_nxt      = 2'd1;
        end else begin
          bytes[nb] = in_char;
          nb        = nb + 2'd1;
        end
      end

      // flush an open escape at end of word
      if (in_last) begin
        if (hc_nxt >= 2'd1) begin
          bytes[nb] = CH_EQ;
          nb        = nb + 2'd1;
        end
        if (hc_nxt >= 2'd2) begin
          bytes[nb] = held_nxt[1];
          nb        = nb + 2'd1;
        end
      end
    end else begin
      bytes[nb] = in_char;
      nb        = nb + 2'd1;
    end
  end

  assign q_data.bytes = bytes;
  assign q_data.cnt   = nb;
  assign q_data.last  = in_last;

  // pending state
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear || (q_push && in_last)) begin
      held_r <= '0;
      hc_r   <= 2'd0;
      halt_r <= 1'b0;
    end else if (q_push) begin
      held_r <= held_nxt;
      hc_r   <= hc_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== rtl/core/ewpd_queue.sv =====
module ewpd_queue import ewpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ewpd_bundle_t push_data,
  input  logic         pop,
  output logic         full,
  output logic         head_valid,
  output ewpd_bundle_t head
);

  ewpd_bundle_t mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rp_r];

  // two-entry bundle queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/ewpd_back.sv =====
module ewpd_back import ewpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         widen_latin1,
  input  logic         head_valid,
  input  ewpd_bundle_t head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         out_no_data,
  output logic         out_eow
);

  logic [1:0] idx_r, idx_nxt;
  logic       hi_r, hi_nxt;
  logic       ovalid_r;
  logic [7:0] obyte_r;
  logic       onodata_r, oeow_r;

  logic [7:0] cur, res;
  logic       wide, done, step, emit;

  // Serialize one bundle, splitting high bytes into UTF-8 pairs when widening is on
  always_comb begin
    cur     = head.bytes[idx_r];
    wide    = widen_latin1 && cur[7];
    res     = cur;
    done    = 1'b0;
    idx_nxt = idx_r;
    hi_nxt  = 1'b0;
    if (head.cnt == 2'd0) begin
      res  = 8'h00;
      done = 1'b1;
    end else if (wide && !hi_r) begin
      res    = UTF8_LEAD | {6'd0, cur[7:6]};
      hi_nxt = 1'b1;
    end else begin
      if (wide) res = UTF8_CONT | (cur & LOW6_MASK);
      if (idx_r == head.cnt - 2'd1) done = 1'b1;
      else idx_nxt = idx_r + 2'd1;
    end
    if (done) idx_nxt = 2'd0;
  end

  assign step = head_valid && (!ovalid_r || out_ready);
  assign emit = step && (head.cnt != 2'd0 || head.last);
  assign pop  = step && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 2'd0;
      hi_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (step) begin
        idx_r <= idx_nxt;
        hi_r  <= hi_nxt;
      end
      if (emit)           ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      obyte_r   <= res;
      onodata_r <= (head.cnt == 2'd0);
      oeow_r    <= head.last && done;
    end
  end

  assign out_valid   = ovalid_r;
  assign out_byte    = obyte_r;
  assign out_no_data = onodata_r;
  assign out_eow     = oeow_r;

endmodule

// ===== rtl/core/encoded_word_payload_decoder.sv =====
// Encoded-word payload decoder.
// in_ch carries one payload character per request with last_char marking the
// final character of the word; out_ch carries decoded bytes, one per request.
// decode_mode (byte address 0) picks base64, Q or raw copy; widen_latin1
// (byte address 4) turns bytes 0x80 and up into two-byte UTF-8. Write the
// registers only while no word is in flight; a write clears pending state.
// The first result of a character passes the queue entry and then the result
// register. The front takes one character per cycle into a two-entry queue
// while the queue is not full; the back drains one result per cycle while the
// receiver is ready, and one character yields up to six results, for a widened
// base64 group. On the final character a lone no_data result carries
// end_of_word when the character produced no byte.
// Reset (synchronous, rst_n low) clears the registers, pending characters,
// the queue and the result valid flag. A stalled receiver holds the result
// register; the queue then fills and in_ch.ready drops.
module encoded_word_payload_decoder import ewpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ewpd_in_if.sink     in_ch,
  ewpd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]   mode_r;
  logic         widen_r;
  logic         cfg_wr;
  logic         q_push, q_pop, q_full, q_head_valid;
  ewpd_bundle_t q_in, q_head;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_B;
      widen_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) mode_r <= pwdata[1:0];
      else                      widen_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_WIDEN) ? {31'd0, widen_r} : {30'd0, mode_r};

  ewpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .decode_mode (mode_r),
    .cfg_clear   (cfg_wr),
    .in_valid    (in_ch.valid),
    .in_char     (in_ch.payload_char),
    .in_last     (in_ch.last_char),
    .in_ready    (in_ch.ready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  ewpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ewpd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .widen_latin1 (widen_r),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_no_data  (out_ch.no_data),
    .out_eow      (out_ch.end_of_word)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("bundle queue overflow");

  // queue never popped while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid) else $error("bundle queue underflow");

  // an end-marker-only result is always the word's last, with a zero byte
  a_no_data_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_data) |-> (out_ch.end_of_word && out_ch.out_byte == 8'h00))
    else $error("no_data result without end marker");

endmodule

// ===== sim/ewpd_checker.sv =====
// Scoreboard for the encoded-word payload decoder.
// Watches the character, result and register channels, predicts the decoded
// bytes of every accepted character request and compares them in order.
module ewpd_checker import ewpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ewpd_in_if          in_mon,
  ewpd_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       no_data;
    logic       eow;
  } decoded_t;

  localparam int REPORT_MAX = 10;

  // predictor copy of the registers and the pending decode state
  logic [1:0] cur_mode;
  logic       widen_on;
  logic [7:0] held[HELD_N];
  int         held_n;
  logic       b64_stopped;

  logic [7:0] step_bytes[$];   // bytes decoded for the current request
  decoded_t   expected[$];     // results still owed by the block

  function automatic int b64_value(input logic [7:0] c);
    int v;
    v = c;
    if (v >= "A" && v <= "Z") return v - "A";
    if (v >= "a" && v <= "z") return v - "a" + 26;
    if (v >= "0" && v <= "9") return v - "0" + 52;
    if (v == "+") return 62;
    if (v == "/") return 63;
    return -1;
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    int v;
    v = c;
    if (v >= "0" && v <= "9") return v - "0";
    if (v >= "a" && v <= "f") return v - "a" + 10;
    if (v >= "A" && v <= "F") return v - "A" + 10;
    return -1;
  endfunction

  function automatic void drop_held();
    foreach (held[i]) held[i] = 8'h00;
    held_n = 0;
    b64_stopped = 1'b0;
  endfunction

  // one decoded byte, split into a UTF-8 pair when widening applies
  function automatic void put_decoded(input logic [7:0] b);
    if (widen_on && b >= UTF8_CONT) begin
      step_bytes.push_back(UTF8_LEAD | (b >> 6));
      step_bytes.push_back(UTF8_CONT | (b & LOW6_MASK));
    end else begin
      step_bytes.push_back(b);
    end
  endfunction

  // Q mode outside an escape
  function automatic void q_plain(input logic [7:0] c);
    if (c == CH_US) begin
      put_decoded(CH_SPACE);
    end else if (c == CH_EQ) begin
      held[0] = CH_EQ;
      held_n = 1;
    end else begin
      put_decoded(c);
    end
  endfunction

  function automatic void b64_char(input logic [7:0] c);
    int a, b, x, y, hi;
    if (b64_stopped) return;
    if (held_n < 3) begin
      held[held_n] = c;
      held_n++;
      return;
    end
    held_n = 0;
    a = b64_value(held[0]);
    b = b64_value(held[1]);
    x = b64_value(held[2]);
    y = b64_value(c);
    // bad first or second character: nothing more until end of word
    if (a < 0 || b < 0) begin
      b64_stopped = 1'b1;
      return;
    end
    put_decoded(8'((a << 2) | (b >> 4)));
    if (x >= 0) put_decoded(8'(((b & 'h0F) << 4) | (x >> 2)));
    if (y >= 0) begin
      // bad third with good fourth keeps both high bits set
      hi = (x >= 0) ? (x & 'h03) : 'h03;
      put_decoded(8'((hi << 6) | y));
    end
  endfunction

  function automatic void q_char(input logic [7:0] c);
    if (held_n == 1) begin
      if (hex_value(c) >= 0) begin
        held[1] = c;
        held_n = 2;
      end else begin
        put_decoded(CH_EQ);
        held_n = 0;
        q_plain(c);
      end
    end else if (held_n >= 2) begin
      held_n = 0;
      if (hex_value(c) >= 0) begin
        put_decoded(8'((hex_value(held[1]) << 4) | hex_value(c)));
      end else begin
        put_decoded(CH_EQ);
        put_decoded(held[1]);
        q_plain(c);
      end
    end else begin
      q_plain(c);
    end
  endfunction

  // decode one accepted character and queue the results it owes
  function automatic void decode_char(input logic [7:0] c, input logic is_last);
    decoded_t r;
    step_bytes.delete();
    if (cur_mode == MODE_B) begin
      b64_char(c);
    end else if (cur_mode == MODE_Q) begin
      q_char(c);
      // an unfinished escape at end of word leaves as plain text
      if (is_last && held_n >= 1) put_decoded(CH_EQ);
      if (is_last && held_n >= 2) put_decoded(held[1]);
    end else begin
      put_decoded(c);
    end
    // lone end marker when the final character gave no byte
    if (is_last && step_bytes.size() == 0) begin
      r.data = 8'h00;
      r.no_data = 1'b1;
      r.eow = 1'b1;
      expected.push_back(r);
    end
    foreach (step_bytes[i]) begin
      r.data = step_bytes[i];
      r.no_data = 1'b0;
      r.eow = is_last && (i == step_bytes.size() - 1);
      expected.push_back(r);
    end
    if (is_last) drop_held();
  endfunction

  function automatic void report(input string what, input decoded_t want,
                                 input decoded_t got);
    fails++;
    if (fails <= REPORT_MAX)
      $display("%0t: %s: expected byte %02h no_data %0b eow %0b, got byte %02h no_data %0b eow %0b",
               $realtime, what, want.data, want.no_data, want.eow,
               got.data, got.no_data, got.eow);
  endfunction

  always @(posedge clk) begin
    decoded_t got, want;
    if (!rst_n) begin
      cur_mode = MODE_B;
      widen_on = 1'b0;
      drop_held();
      expected.delete();
    end else begin
      // result request: compare against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.data = out_mon.out_byte;
        got.no_data = out_mon.no_data;
        got.eow = out_mon.end_of_word;
        if (expected.size() == 0) begin
          want = '0;
          report("unexpected result", want, got);
        end else begin
          want = expected.pop_front();
          if (got.data !== want.data || got.no_data !== want.no_data ||
              got.eow !== want.eow)
            report("result mismatch", want, got);
        end
      end
      if (in_mon.valid && in_mon.ready)
        decode_char(in_mon.payload_char, in_mon.last_char);
      // register write; either register clears the pending state
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) cur_mode = pwdata[1:0];
        else widen_on = pwdata[0];
        drop_held();
      end
    end
    pending = expected.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Stimulus and verdict for the encoded-word payload decoder.
module tb_top;
  import ewpd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;

  localparam logic [1:0] MODE_RAW   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam string B64_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam string HEX_CHARS = "0123456789abcdefABCDEF";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;
  int quiet_cycles;
  bit idle_on;
  bit squeeze;

  ewpd_in_if  in_ch ();
  ewpd_out_if out_ch ();

  encoded_word_payload_decoder uut (
    .clk, .rst_n, .in_ch, .out_ch,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ewpd_checker chk (
    .clk, .rst_n, .in_mon(in_ch), .out_mon(out_ch),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fails(fail_count), .pending(pending_count)
  );

  always #HALF_PERIOD clk = ~clk;

  // watchdog: too long without any request moving ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        squeeze = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic apb_write(input logic sel, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one character request, with an optional gap in front
  task automatic send_char(input logic [7:0] c, input logic is_last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_char <= c;
    in_ch.last_char    <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // drain, let the block settle, then write both registers
  task automatic configure(input logic [1:0] mode, input logic widen);
    // step off the edge so the last accepted request is already counted
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_MODE, {30'd0, mode});
    apb_write(REG_WIDEN, {31'd0, widen});
  endtask

  // random words shaped for the mode until about target characters went out
  task automatic random_words(input logic [1:0] mode, input int target);
    logic [7:0] w[$];
    int sent, r;
    sent = 0;
    while (sent < target) begin
      w.delete();
      if (mode == MODE_B) begin
        if ($urandom_range(0, 9) != 0) begin
          // whole groups, mostly clean, with sparse padding and junk
          repeat (4 * $urandom_range(1, 4)) begin
            r = $urandom_range(0, 39);
            if (r == 0) w.push_back(CH_EQ);
            else if (r == 1) w.push_back(8'($urandom_range(0, 255)));
            else w.push_back(B64_CHARS[$urandom_range(0, 63)]);
          end
          if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) w.push_back(B64_CHARS[$urandom_range(0, 63)]);
        end else begin
          repeat ($urandom_range(1, 9)) w.push_back(8'($urandom_range(0, 255)));
        end
      end else if (mode == MODE_Q) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 9))
            0: w.push_back(CH_US);
            1, 2: begin
              w.push_back(CH_EQ);
              w.push_back(HEX_CHARS[$urandom_range(0, 21)]);
              w.push_back(HEX_CHARS[$urandom_range(0, 21)]);
            end
            3: begin
              w.push_back(CH_EQ);
              w.push_back(HEX_CHARS[$urandom_range(0, 21)]);
              w.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            4: begin
              w.push_back(CH_EQ);
              w.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            5: w.push_back(CH_EQ);
            6, 7: w.push_back(8'($urandom_range(8'h20, 8'h7E)));
            default: w.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 10)) w.push_back(8'($urandom_range(0, 255)));
      end
      foreach (w[i]) send_char(w[i], i == w.size() - 1);
      sent += w.size();
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.payload_char <= 8'h00;
    in_ch.last_char    <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= 3'd0;
    pwdata             <= 32'd0;
    idle_on = 1'b1;
    squeeze = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // base64: padded third quirk, padded fourth plus dropped partial group,
    // bad first character stopping the word
    configure(MODE_B, 1'b0);
    send_text("QQ=A");
    send_text("QUI=QU");
    send_text("*AAA/");
    squeeze = 1'b1;
    random_words(MODE_B, 70);

    configure(MODE_Q, 1'b0);
    random_words(MODE_Q, 70);

    // raw copy of both byte extremes
    configure(MODE_RAW, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    random_words(MODE_RAW, 60);

    // widened base64: six result bytes from one group
    configure(MODE_B, 1'b1);
    send_text("////");
    squeeze = 1'b1;
    random_words(MODE_B, 70);

    // widened escape, underscore, broken escape, '=' at end of word
    configure(MODE_Q, 1'b1);
    send_text("=E9_=4g=");
    random_words(MODE_Q, 70);

    configure(MODE_SPARE, 1'b1);
    random_words(MODE_RAW, 40);

    // closing stretch with both sides running flat out
    configure(MODE_B, 1'b0);
    idle_on = 1'b0;
    random_words(MODE_B, 60);

    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
